// ===== rtl/lfucl_pkg.sv =====
// Shared types, codes and constants of the LFU cache with LRU tie-break.
`timescale 1ns / 1ps
package lfucl_pkg;

  localparam int unsigned EntriesDef = 16;
  localparam int unsigned CapW       = 5;
  localparam logic [CapW-1:0] CapReset = 5'd16;

  localparam logic KindGet = 1'b0;
  localparam logic KindPut = 1'b1;

  localparam logic [31:0] CountMax = 32'hFFFF_FFFF;
  localparam logic signed [31:0] MissValue = -32'sd1;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] read_value;
  } rsp_t;

  typedef enum logic [2:0] {
    StIdle,
    StScan,
    StScanEnd,
    StDecide,
    StSweep,
    StSweepEnd,
    StDone
  } state_e;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic sweep_step;
    logic decide;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic last;
    logic act;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/lfucl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module lfucl_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lfucl_ctrl.sv =====
// Controller state machine sequencing scan, decision, rank sweep and result beat.
`timescale 1ns / 1ps
module lfucl_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  lfucl_pkg::sts_t sts_i,
  output lfucl_pkg::cmd_t cmd_o
);
  import lfucl_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = StScan;
        end
      end
      StScan: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.last) state_d = StScanEnd;
      end
      StScanEnd: state_d = StDecide;
      StDecide: begin
        cmd_o.decide = 1'b1;
        state_d      = sts_i.act ? StSweep : StDone;
      end
      StSweep: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.last) state_d = StSweepEnd;
      end
      StSweepEnd: state_d = StDone;
      StDone: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

endmodule

// ===== rtl/lfucl_dpath.sv =====
// Datapath: entry storage, scan and sweep pipeline, victim choice and result register.
`timescale 1ns / 1ps
module lfucl_dpath #(
  parameter int unsigned ENTRIES = lfucl_pkg::EntriesDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  lfucl_pkg::req_t                   in_data_i,
  input  logic                              cfg_we_i,
  input  logic [lfucl_pkg::CapW-1:0]        cfg_wdata_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output lfucl_pkg::rsp_t                   out_data_o,
  input  lfucl_pkg::cmd_t                   cmd_i,
  output lfucl_pkg::sts_t                   sts_o
);
  import lfucl_pkg::*;

  localparam int unsigned IW   = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
  localparam int unsigned UW   = $clog2(ENTRIES + 1);
  localparam int unsigned CW   = UW > CapW ? UW : CapW;
  localparam int unsigned RECW = 64 + IW;

  logic [CapW-1:0] cap_q;
  req_t            req_q;
  logic [IW-1:0]   cnt_q;
  logic [ENTRIES-1:0] valid_q;

  logic            p_vld_q, p_sweep_q;
  logic [IW-1:0]   p_idx_q;

  logic            hit_q, vic_any_q, free_any_q;
  logic [IW-1:0]   hit_idx_q, vic_idx_q, free_idx_q;
  logic [IW-1:0]   hit_rank_q, vic_rank_q;
  logic [31:0]     vic_cnt_q;
  logic [UW-1:0]   used_q;

  logic [IW-1:0]   s_q, r_q;
  logic            act_q;

  logic            out_valid_q;
  rsp_t            out_q;

  logic [RECW-1:0] rec_rd, rec_wr;
  logic [31:0]     data_rd;
  logic [31:0]     rd_key, rd_cnt;
  logic [IW-1:0]   rd_rank;
  logic            step, evict, act_d, get_hit;
  logic [CW-1:0]   cap_eff, used_ext;

  assign step    = cmd_i.scan_step | cmd_i.sweep_step;
  assign rd_key  = rec_rd[RECW-1 -: 32];
  assign rd_cnt  = rec_rd[IW +: 32];
  assign rd_rank = rec_rd[IW-1:0];

  assign cap_eff  = (CW'(cap_q) > CW'(ENTRIES)) ? CW'(ENTRIES) : CW'(cap_q);
  assign used_ext = CW'(used_q);
  assign evict    = used_ext >= cap_eff;
  assign get_hit  = (req_q.kind == KindGet) && hit_q;
  assign act_d    = (req_q.kind == KindGet) ? hit_q : (cap_q != '0);

  lfucl_ram #(.WIDTH(RECW), .DEPTH(ENTRIES)) u_rec_ram (
    .clk_i   (clk_i),
    .we_i    (p_vld_q & p_sweep_q),
    .waddr_i (p_idx_q),
    .wdata_i (rec_wr),
    .re_i    (step),
    .raddr_i (cnt_q),
    .rdata_o (rec_rd)
  );

  lfucl_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_data_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.decide & (req_q.kind == KindPut) & act_d),
    .waddr_i (hit_q ? hit_idx_q : (evict ? vic_idx_q : free_idx_q)),
    .wdata_i (req_q.value),
    .re_i    (cmd_i.decide),
    .raddr_i (hit_idx_q),
    .rdata_o (data_rd)
  );

  always_comb begin
    rec_wr = rec_rd;
    if (p_idx_q == s_q) begin
      if (hit_q) begin
        rec_wr = {rd_key, (rd_cnt == CountMax) ? rd_cnt : rd_cnt + 32'd1, IW'(0)};
      end else begin
        rec_wr = {req_q.key, 32'd1, IW'(0)};
      end
    end else if (valid_q[p_idx_q] && (rd_rank < r_q)) begin
      rec_wr = {rd_key, rd_cnt, rd_rank + IW'(1)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CapReset;
      valid_q     <= '0;
      cnt_q       <= '0;
      p_vld_q     <= 1'b0;
      p_sweep_q   <= 1'b0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      vic_any_q   <= 1'b0;
      free_any_q  <= 1'b0;
      used_q      <= '0;
      act_q       <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      p_vld_q   <= step;
      p_sweep_q <= cmd_i.sweep_step;
      if (step) begin
        cnt_q <= (cnt_q == IW'(ENTRIES - 1)) ? '0 : cnt_q + IW'(1);
      end
      if (cmd_i.load) begin
        hit_q      <= 1'b0;
        vic_any_q  <= 1'b0;
        free_any_q <= 1'b0;
        used_q     <= '0;
        cnt_q      <= '0;
      end
      if (p_vld_q && !p_sweep_q) begin
        if (valid_q[p_idx_q]) begin
          used_q <= used_q + UW'(1);
          if (rd_key == req_q.key) hit_q <= 1'b1;
          if (!vic_any_q || (rd_cnt < vic_cnt_q) ||
              ((rd_cnt == vic_cnt_q) && (rd_rank > vic_rank_q))) begin
            vic_any_q <= 1'b1;
          end
        end else if (!free_any_q) begin
          free_any_q <= 1'b1;
        end
      end
      if (cmd_i.decide) act_q <= act_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
        if (act_q) valid_q[s_q] <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) req_q <= in_data_i;
    p_idx_q <= cnt_q;
    if (p_vld_q && !p_sweep_q && valid_q[p_idx_q]) begin
      if (rd_key == req_q.key) begin
        hit_idx_q  <= p_idx_q;
        hit_rank_q <= rd_rank;
      end
      if (!vic_any_q || (rd_cnt < vic_cnt_q) ||
          ((rd_cnt == vic_cnt_q) && (rd_rank > vic_rank_q))) begin
        vic_idx_q  <= p_idx_q;
        vic_cnt_q  <= rd_cnt;
        vic_rank_q <= rd_rank;
      end
    end
    if (p_vld_q && !p_sweep_q && !valid_q[p_idx_q] && !free_any_q) begin
      free_idx_q <= p_idx_q;
    end
    if (cmd_i.decide) begin
      s_q <= hit_q ? hit_idx_q : (evict ? vic_idx_q : free_idx_q);
      r_q <= hit_q ? hit_rank_q : (evict ? vic_rank_q : IW'(used_q));
    end
    if (cmd_i.finish) begin
      out_q.found      <= get_hit;
      out_q.read_value <= get_hit ? $signed(data_rd) : MissValue;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_data_o   = out_q;
  assign sts_o.last     = (cnt_q == IW'(ENTRIES - 1));
  assign sts_o.act      = act_d;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

endmodule

// ===== rtl/lfu_cache_lru_tiebreak_core.sv =====
// Top level of the LFU key-value cache with LRU tie-break.
`timescale 1ns / 1ps
// Usage:
//   Request channel in_valid_i / in_stall_o / in_data_i carries get or put beats.
//   Result channel out_valid_o / out_stall_i / out_data_o returns one beat per
//   request: found and the stored value on a get hit, otherwise -1.
//   cfg_we_i / cfg_wdata_i write the capacity register; users write it only while idle (not enforced).
// Sequence:
//   One request at a time. A key and victim scan reads one entry a cycle from
//   the entry RAM, a decision step follows, and when an entry is touched a
//   rank sweep rewrites every entry. The result is registered once the output
//   register is free, and the next request is taken when the block is idle again.
// Reset:
//   All entries become empty and capacity returns to 16; no clearing pass.
// Stall:
//   A finished result holds in the output register while out_stall_i is high;
//   the next request is still accepted and runs until its own result is due.
module lfu_cache_lru_tiebreak_core #(
  parameter int unsigned ENTRIES = lfucl_pkg::EntriesDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  lfucl_pkg::req_t            in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output lfucl_pkg::rsp_t            out_data_o,
  input  logic                       cfg_we_i,
  input  logic [lfucl_pkg::CapW-1:0] cfg_wdata_i
);
  import lfucl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  lfucl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  lfucl_dpath #(.ENTRIES(ENTRIES)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ===== tb/tb_lfu_cache_lru_tiebreak_core.sv =====
// Testbench for the LFU cache core: directed table plus random requests checked by a predictor.
`timescale 1ns / 1ps
module tb_lfu_cache_lru_tiebreak_core;
  import lfucl_pkg::*;

  localparam int unsigned NumEntries = 16;

  typedef struct {
    req_t       req;
    logic       has_rsp;
    rsp_t       rsp;
  } row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;
  logic cfg_we;
  logic [CapW-1:0] cfg_wdata;

  lfu_cache_lru_tiebreak_core #(.ENTRIES(NumEntries)) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata)
  );

  logic [CapW-1:0] cache_cap;
  logic            slot_valid [NumEntries];
  logic [31:0]     slot_key   [NumEntries];
  logic [31:0]     slot_data  [NumEntries];
  logic [31:0]     slot_uses  [NumEntries];
  int unsigned     slot_rank  [NumEntries];

  rsp_t pending_rsp[$];
  int   mismatches;
  bit   hold_off;
  logic [31:0] key_pool [8];

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tb_lfu_cache_lru_tiebreak_core failed");
    $finish;
  end

  function automatic void cache_clear();
    cache_cap = CapReset;
    for (int i = 0; i < NumEntries; i++) begin
      slot_valid[i] = 1'b0;
      slot_key[i] = '0;
      slot_data[i] = '0;
      slot_uses[i] = '0;
      slot_rank[i] = 0;
    end
  endfunction

  function automatic void make_recent(int s);
    for (int i = 0; i < NumEntries; i++) begin
      if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
    end
    slot_rank[s] = 0;
    if (slot_uses[s] != CountMax) slot_uses[s]++;
  endfunction

  function automatic rsp_t cache_access(req_t r);
    rsp_t o;
    int cap;
    int hit;
    int used;
    int slot;
    int v;
    o.found = 1'b0;
    o.read_value = MissValue;
    cap = (cache_cap > NumEntries) ? NumEntries : cache_cap;
    hit = -1;
    used = 0;
    slot = -1;
    v = -1;
    for (int i = 0; i < NumEntries; i++) begin
      if (slot_valid[i]) begin
        used++;
        if (slot_key[i] == r.key) hit = i;
      end
    end
    if (r.kind == KindGet) begin
      if (hit >= 0) begin
        o.found = 1'b1;
        o.read_value = slot_data[hit];
        make_recent(hit);
      end
      return o;
    end
    if (cap == 0) return o;
    if (hit >= 0) begin
      slot_data[hit] = r.value;
      make_recent(hit);
      return o;
    end
    if (used >= cap) begin
      for (int i = 0; i < NumEntries; i++) begin
        if (slot_valid[i] && (v < 0 || slot_uses[i] < slot_uses[v] ||
            (slot_uses[i] == slot_uses[v] && slot_rank[i] > slot_rank[v]))) v = i;
      end
      if (v >= 0) begin
        slot_valid[v] = 1'b0;
        for (int i = 0; i < NumEntries; i++) begin
          if (slot_valid[i] && slot_rank[i] > slot_rank[v]) slot_rank[i]--;
        end
        slot = v;
      end
    end
    if (slot < 0) begin
      for (int i = NumEntries - 1; i >= 0; i--) begin
        if (!slot_valid[i]) slot = i;
      end
    end
    if (slot < 0) return o;
    for (int i = 0; i < NumEntries; i++) begin
      if (slot_valid[i]) slot_rank[i]++;
    end
    slot_valid[slot] = 1'b1;
    slot_key[slot] = r.key;
    slot_data[slot] = r.value;
    slot_uses[slot] = 32'd1;
    slot_rank[slot] = 0;
    return o;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_req(req_t r, logic has_rsp, rsp_t rsp);
    rsp_t pred;
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
    pred = cache_access(r);
    if (has_rsp && pred !== rsp) begin
      mismatches++;
      if (mismatches <= 10)
        $display("table row mismatch: expected %h predicted %h", rsp, pred);
    end
    pending_rsp.push_back(pred);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (2 * NumEntries + 12) @(posedge clk);
  endtask

  task automatic write_cap(logic [CapW-1:0] c);
    cfg_we <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we <= 1'b0;
    cache_cap = c;
  endtask

  function automatic req_t mk(logic k, logic [31:0] key, logic [31:0] val);
    req_t r;
    r.kind = k;
    r.key = key;
    r.value = val;
    return r;
  endfunction

  function automatic req_t rand_req();
    logic [31:0] key;
    if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, 7)] + $urandom_range(0, 23);
    else key = $urandom;
    return mk(1'($urandom_range(0, 1)), key, $urandom);
  endfunction

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat %h", out_data);
      end else begin
        rsp_t e;
        e = pending_rsp[0];
        pending_rsp.delete(0);
        if (out_data.found !== e.found || out_data.read_value !== e.read_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected found=%b value=%h, got found=%b value=%h",
                     e.found, e.read_value, out_data.found, out_data.read_value);
        end
      end
    end
  end

  always @(posedge clk) begin
    int g;
    if (hold_off) begin
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 30) begin
      g = gap_len();
      out_stall <= 1'b1;
      repeat (g + 1) @(posedge clk);
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    hold_off = 1'b0;
    for (int i = 0; i < 400; i++) @(posedge clk);
    hold_off = 1'b1;
    repeat (300) @(posedge clk);
    hold_off = 1'b0;
  end

  initial begin
    row_t tbl[$];
    row_t row;
    rsp_t miss;
    rsp_t hitv;
    logic [CapW-1:0] caps [6];
    miss.found = 1'b0;
    miss.read_value = MissValue;
    caps = '{5'd0, 5'd1, 5'd31, 5'd3, 5'd16, 5'd8};
    mismatches = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    cache_clear();
    for (int i = 0; i < 8; i++) key_pool[i] = $urandom;
    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFF0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    row.has_rsp = 1'b1;
    row.rsp = miss;
    row.req = mk(KindGet, 32'h0, 32'h0);                  tbl.push_back(row);
    row.req = mk(KindGet, 32'h8000_0000, 32'hFFFF_FFFF);  tbl.push_back(row);
    row.req = mk(KindPut, 32'h8000_0000, 32'h7FFF_FFFF);  tbl.push_back(row);
    row.req = mk(KindPut, 32'h7FFF_FFFF, 32'h8000_0000);  tbl.push_back(row);
    row.req = mk(KindPut, 32'hFFFF_FFFF, 32'h0);          tbl.push_back(row);
    hitv.found = 1'b1;
    hitv.read_value = 32'h7FFF_FFFF;
    row.rsp = hitv;
    row.req = mk(KindGet, 32'h8000_0000, 32'h1234_5678);  tbl.push_back(row);
    hitv.read_value = 32'h8000_0000;
    row.rsp = hitv;
    row.req = mk(KindGet, 32'h7FFF_FFFF, 32'h0);          tbl.push_back(row);
    row.has_rsp = 1'b0;
    row.req = mk(KindPut, 32'h7FFF_FFFF, 32'hFFFF_FFFF);  tbl.push_back(row);
    for (int k = 0; k < 15; k++) begin
      row.req = mk(KindPut, 32'h100 + k, 32'h1000 + k);   tbl.push_back(row);
    end
    row.req = mk(KindGet, 32'hFFFF_FFFF, 32'h0);          tbl.push_back(row);
    row.req = mk(KindGet, 32'h100, 32'h0);                tbl.push_back(row);
    foreach (tbl[i]) send_req(tbl[i].req, tbl[i].has_rsp, tbl[i].rsp);

    // pause until all results are back
    drain();
    foreach (caps[p]) begin
      write_cap(caps[p]);
      repeat (135) begin
        send_req(rand_req(), 1'b0, miss);
      end
      drain();
    end
    if (mismatches == 0) begin
      $display("tb_lfu_cache_lru_tiebreak_core passed");
    end else begin
      $display("tb_lfu_cache_lru_tiebreak_core failed");
    end
    $finish;
  end

endmodule
